/* hw/rtl/tfes_pkg.sv */
// Shared types and constants for the top-four energy selector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tfes_pkg;

    // Default sizes of the kept-shower store
    localparam int SLOTS_DEF         = 4;
    localparam int ENERGY_BITS_DEF   = 17;
    localparam int MOMENTUM_BITS_DEF = 18;

    // Fixed port field widths
    localparam int IN_E_W      = 17;
    localparam int IN_M_W      = 18;
    localparam int OUT_M_W     = 18;
    localparam int RANK_W      = 2;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_USED_W  = RANK_W + 1 + 3 * OUT_M_W;

    // Input tdata bit positions
    localparam int IN_GOOD_LSB = 0;
    localparam int IN_HOT_LSB  = 1;
    localparam int IN_E_LSB    = 2;
    localparam int IN_X_LSB    = IN_E_LSB + IN_E_W;
    localparam int IN_Y_LSB    = IN_X_LSB + IN_M_W;
    localparam int IN_Z_LSB    = IN_Y_LSB + IN_M_W;

    // Command codes carried in tuser
    localparam logic CMD_SHOWER = 1'b0;
    localparam logic CMD_EOE    = 1'b1;

    // Front-to-back queue depth, power of two
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic vld;
        logic flush;
    } t_q_head;

endpackage

/* hw/rtl/top_four_energy_selector.sv */
// Top level of the top-four energy selector: front queue, ranked store, emitter.
// Depends on tfes_pkg, tfes_front, tfes_back and tfes_emit.
`timescale 1ns / 1ps

// Keeps the SLOTS highest-energy good, non-hot showers of an event and, on an
// end-of-event command (tuser = 1), clears the store and streams one result per
// rank, best first, from a snapshot of it. Equal energies rank in arrival order.
// A shower transaction is taken every cycle while the two-entry queue is not
// full; it is written into the queue on acceptance and enters the store at the
// edge where it leaves the queue; rejected showers never enter the queue. An
// end of event leaves the queue once the emitter is free or is handing over its
// final rank and yields SLOTS output transactions from the emitter's shift
// register, one per cycle while m_axis_tready is high, whatever the shower count.
module top_four_energy_selector #(
    parameter int SLOTS         = tfes_pkg::SLOTS_DEF,
    parameter int ENERGY_BITS   = tfes_pkg::ENERGY_BITS_DEF,
    parameter int MOMENTUM_BITS = tfes_pkg::MOMENTUM_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // shower_good, shower_hot, shower_energy, mom_x, mom_y, mom_z, zero pad
    input  logic [tfes_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // cmd
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // rank, present, out_x, out_y, out_z, zero pad
    output logic [tfes_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast
);
    import tfes_pkg::*;

    t_q_head                                q_head;
    logic [ENERGY_BITS-1:0]                 q_energy;
    logic [3*MOMENTUM_BITS-1:0]             q_mom;
    logic                                   pop, load, emit_free;
    logic [SLOTS-1:0]                       snap_fill;
    logic [SLOTS-1:0][3*MOMENTUM_BITS-1:0]  snap_mom;

    tfes_front #(
        .ENERGY_BITS   (ENERGY_BITS),
        .MOMENTUM_BITS (MOMENTUM_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_pop         (pop),
        .o_q           (q_head),
        .o_energy      (q_energy),
        .o_mom         (q_mom)
    );

    tfes_back #(
        .SLOTS         (SLOTS),
        .ENERGY_BITS   (ENERGY_BITS),
        .MOMENTUM_BITS (MOMENTUM_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q           (q_head),
        .i_energy      (q_energy),
        .i_mom         (q_mom),
        .i_emit_free   (emit_free),
        .o_pop         (pop),
        .o_load        (load),
        .o_snap_fill   (snap_fill),
        .o_snap_mom    (snap_mom)
    );

    tfes_emit #(
        .SLOTS         (SLOTS),
        .MOMENTUM_BITS (MOMENTUM_BITS)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_snap_fill   (snap_fill),
        .i_snap_mom    (snap_mom),
        .o_free        (emit_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* hw/rtl/tfes_front.sv */
// Input side: accepts stream transactions, drops unusable showers, queues the rest.
// Depends on tfes_pkg.
`timescale 1ns / 1ps

module tfes_front #(
    parameter int ENERGY_BITS   = tfes_pkg::ENERGY_BITS_DEF,
    parameter int MOMENTUM_BITS = tfes_pkg::MOMENTUM_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // good, hot, shower_energy, mom_x, mom_y, mom_z, zero pad
    input  logic [tfes_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // cmd
    input  logic [0:0]                        s_axis_tuser,
    input  logic                              i_pop,
    output tfes_pkg::t_q_head                 o_q,
    output logic [ENERGY_BITS-1:0]            o_energy,
    output logic [3*MOMENTUM_BITS-1:0]        o_mom
);
    import tfes_pkg::*;

    localparam int EW  = 1 + ENERGY_BITS + 3 * MOMENTUM_BITS;
    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    logic [EW-1:0]  r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [QAW:0]   r_cnt, n_cnt;
    logic           w_acc, w_push, w_keep, w_eoe;
    logic [EW-1:0]  w_entry, w_head;

    assign s_axis_tready = (r_cnt != (QAW+1)'(Q_DEPTH));
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_eoe  = (s_axis_tuser[0] == CMD_EOE);
    assign w_keep = s_axis_tdata[IN_GOOD_LSB] && !s_axis_tdata[IN_HOT_LSB];
    assign w_push = w_acc && (w_eoe || w_keep);

    assign w_entry = {w_eoe,
                      ENERGY_BITS'(s_axis_tdata[IN_E_LSB +: IN_E_W]),
                      MOMENTUM_BITS'($signed(s_axis_tdata[IN_X_LSB +: IN_M_W])),
                      MOMENTUM_BITS'($signed(s_axis_tdata[IN_Y_LSB +: IN_M_W])),
                      MOMENTUM_BITS'($signed(s_axis_tdata[IN_Z_LSB +: IN_M_W]))};

    assign w_head    = r_mem[r_rp];
    assign o_q.vld   = (r_cnt != '0);
    assign o_q.flush = w_head[EW-1];
    assign o_energy  = w_head[EW-2 -: ENERGY_BITS];
    assign o_mom     = w_head[3*MOMENTUM_BITS-1:0];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = r_rp + 1'b1;
        end
        if (w_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_entry;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAW+1)'(Q_DEPTH))
        else $error("queue count exceeds depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("pop from empty queue");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (QAW+1)'(Q_DEPTH)) && !i_pop |=> r_cnt == (QAW+1)'(Q_DEPTH))
        else $error("full queue lost an entry");

endmodule

/* hw/rtl/tfes_back.sv */
// Ranked shower store: inserts queued showers in energy order, hands a snapshot
// to the emitter at end of event. Depends on tfes_pkg.
`timescale 1ns / 1ps

module tfes_back #(
    parameter int SLOTS         = tfes_pkg::SLOTS_DEF,
    parameter int ENERGY_BITS   = tfes_pkg::ENERGY_BITS_DEF,
    parameter int MOMENTUM_BITS = tfes_pkg::MOMENTUM_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  tfes_pkg::t_q_head                       i_q,
    input  logic [ENERGY_BITS-1:0]                  i_energy,
    input  logic [3*MOMENTUM_BITS-1:0]              i_mom,
    input  logic                                    i_emit_free,
    output logic                                    o_pop,
    output logic                                    o_load,
    output logic [SLOTS-1:0]                        o_snap_fill,
    output logic [SLOTS-1:0][3*MOMENTUM_BITS-1:0]   o_snap_mom
);
    import tfes_pkg::*;

    logic [SLOTS-1:0]                       r_fill, n_fill;
    logic [SLOTS-1:0][ENERGY_BITS-1:0]      r_energy, n_energy;
    logic [SLOTS-1:0][3*MOMENTUM_BITS-1:0]  r_mom, n_mom;
    logic [SLOTS-1:0]                       w_lt, w_shift, w_hit;
    logic                                   w_ins;

    assign o_pop       = i_q.vld && (!i_q.flush || i_emit_free);
    assign o_load      = o_pop && i_q.flush;
    assign w_ins       = o_pop && !i_q.flush;
    assign o_snap_fill = r_fill;
    assign o_snap_mom  = r_mom;

    always_comb begin
        logic acc;
        acc = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            w_lt[i]    = !r_fill[i] || (r_energy[i] < i_energy);
            w_shift[i] = acc;
            w_hit[i]   = w_lt[i] && !acc;
            acc        = acc || w_lt[i];
        end
    end

    always_comb begin
        n_fill   = r_fill;
        n_energy = r_energy;
        n_mom    = r_mom;
        if (o_load) begin
            n_fill = '0;
        end else if (w_ins) begin
            for (int i = 1; i < SLOTS; i++) begin
                if (w_shift[i]) begin
                    n_fill[i]   = r_fill[i-1];
                    n_energy[i] = r_energy[i-1];
                    n_mom[i]    = r_mom[i-1];
                end
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (w_hit[i]) begin
                    n_fill[i]   = 1'b1;
                    n_energy[i] = i_energy;
                    n_mom[i]    = i_mom;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_energy <= n_energy;
        r_mom    <= n_mom;
    end

    a_fill_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill & (r_fill + 1'b1)) == '0)
        else $error("filled slots not contiguous from top rank");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |=> r_fill == '0)
        else $error("slots not cleared after end of event");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins && !r_fill[SLOTS-1] |=> $countones(r_fill) == $past($countones(r_fill)) + 1)
        else $error("insert into free slot lost a shower");

endmodule

/* hw/rtl/tfes_emit.sv */
// Result emitter: holds an end-of-event snapshot and streams one ranked result
// per transaction. Depends on tfes_pkg.
`timescale 1ns / 1ps

module tfes_emit #(
    parameter int SLOTS         = tfes_pkg::SLOTS_DEF,
    parameter int MOMENTUM_BITS = tfes_pkg::MOMENTUM_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_load,
    input  logic [SLOTS-1:0]                        i_snap_fill,
    input  logic [SLOTS-1:0][3*MOMENTUM_BITS-1:0]   i_snap_mom,
    output logic                                    o_free,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // rank, present, out_x, out_y, out_z, zero pad
    output logic [tfes_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                    m_axis_tlast
);
    import tfes_pkg::*;

    localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MB = MOMENTUM_BITS;

    logic                           r_busy, n_busy;
    logic [CW-1:0]                  r_cnt, n_cnt;
    logic [SLOTS-1:0]               r_fill, n_fill;
    logic [SLOTS-1:0][3*MB-1:0]     r_mom, n_mom;
    logic                           w_take, w_last;
    logic signed [MB-1:0]           w_x, w_y, w_z;
    logic signed [MB-1:0]           w_absent;
    logic signed [OUT_M_W-1:0]      w_ox, w_oy, w_oz;

    assign w_absent = {1'b1, {(MB-1){1'b0}}};
    assign w_last   = (r_cnt == CW'(SLOTS - 1));
    assign w_take   = r_busy && m_axis_tready;
    assign o_free   = !r_busy || (m_axis_tready && w_last);

    assign w_x  = r_fill[0] ? $signed(r_mom[0][3*MB-1 -: MB]) : w_absent;
    assign w_y  = r_fill[0] ? $signed(r_mom[0][2*MB-1 -: MB]) : w_absent;
    assign w_z  = r_fill[0] ? $signed(r_mom[0][MB-1:0])       : w_absent;
    assign w_ox = OUT_M_W'(w_x);
    assign w_oy = OUT_M_W'(w_y);
    assign w_oz = OUT_M_W'(w_z);

    assign m_axis_tvalid = r_busy;
    assign m_axis_tlast  = w_last;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), w_oz, w_oy, w_ox,
                            r_fill[0], RANK_W'(r_cnt)};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_fill = r_fill;
        n_mom  = r_mom;
        if (i_load) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_fill = i_snap_fill;
            n_mom  = i_snap_mom;
        end else if (w_take) begin
            if (w_last) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt + 1'b1;
                for (int i = 0; i < SLOTS - 1; i++) begin
                    n_fill[i] = r_fill[i+1];
                    n_mom[i]  = r_mom[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill <= n_fill;
        r_mom  <= n_mom;
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !r_busy || (w_take && w_last))
        else $error("snapshot loaded over a run in progress");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && w_last && !i_load |=> !r_busy)
        else $error("emitter still busy after final rank");

    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_busy && r_cnt == '0)
        else $error("run did not restart at top rank");

endmodule
